### rtl/core/bgtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph template matcher package
// Shared constants, request and result codes, sequencer states and the
// 66-pixel population count used by the matcher.
// ----------------------------------------------------------------------------
package bgtm_pkg;

  // Table geometry
  localparam int TEMPLATES_DEF = 64;
  localparam int GLYPH_PIXELS  = 66;
  localparam int UPPER_W       = 36;
  localparam int LOWER_W       = 30;
  localparam int SLOT_W        = 6;
  localparam int LABEL_W       = 4;
  localparam int SCORE_W       = 7;
  localparam int GRADE_W       = 3;

  // Stream payload widths (byte padded)
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;
  localparam int KIND_W     = 2;

  // Config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_MIN_SET = 2'd0;
  localparam logic [1:0] REG_LEARN   = 2'd1;
  localparam logic [1:0] REG_DOUBT   = 2'd2;

  localparam logic [SCORE_W-1:0] MIN_SET_RST = 7'd10;
  localparam logic [SCORE_W-1:0] LEARN_RST   = 7'd56;
  localparam logic [SCORE_W-1:0] DOUBT_RST   = 7'd50;
  localparam logic [SCORE_W-1:0] FULL_SCORE  = 7'd66;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

  // Result grades
  localparam logic [GRADE_W-1:0] GRADE_EXACT     = 3'd0;
  localparam logic [GRADE_W-1:0] GRADE_LEARNABLE = 3'd1;
  localparam logic [GRADE_W-1:0] GRADE_DOUBTFUL  = 3'd2;
  localparam logic [GRADE_W-1:0] GRADE_REJECTED  = 3'd3;
  localparam logic [GRADE_W-1:0] GRADE_BLANK     = 3'd4;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LIT   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  // Lit pixel count of a glyph: per-row counts, then two half sums
  function automatic logic [SCORE_W-1:0] pop66(input logic [GLYPH_PIXELS-1:0] v);
    logic [2:0]         row_cnt [11];
    logic [SCORE_W-1:0] half_a;
    logic [SCORE_W-1:0] half_b;
    for (int r = 0; r < 11; r++) begin
      row_cnt[r] = 3'd0;
      for (int c = 0; c < 6; c++) begin
        row_cnt[r] = row_cnt[r] + 3'(v[r*6+c]);
      end
    end
    half_a = '0;
    half_b = '0;
    for (int r = 0; r < 6; r++) begin
      half_a = half_a + 7'(row_cnt[r]);
    end
    for (int r = 6; r < 11; r++) begin
      half_b = half_b + 7'(row_cnt[r]);
    end
    return half_a + half_b;
  endfunction

endpackage
`default_nettype wire

### rtl/core/binary_glyph_template_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary glyph template matcher
// Nearest-template digit recognition over 11x6 binary glyphs.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the kind (load, classify,
//   clear), s_tdata the slot, label and 66 pixels. Only classify requests give
//   a result on the m_ stream: grade, matched digit and score. Thresholds are
//   to be written over the APB-style port while the block is idle (unchecked).
// Sequence:
//   A load is written as it is taken. A clear sweeps the template memory, one
//   slot a cycle. A classify result comes from a lit count, then each slot in
//   turn through the shared popcount and compare unit (one memory read port),
//   then a grade step; a blank glyph skips the slots. s_tready is low
//   throughout, so one classify holds the input until its result is in the
//   output register.
// Reset:
//   After reset the same clearing pass runs before the first request is
//   taken; thresholds return to 10 / 56 / 50.
// Stalls:
//   The result waits in an output register; a new request is taken while it
//   waits, and the next result holds in the grade step until it is taken.
// ----------------------------------------------------------------------------
module binary_glyph_template_matcher
  import bgtm_pkg::*;
#(
  parameter int TEMPLATES = TEMPLATES_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  // request stream
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire [IN_DATA_W-1:0]    s_tdata,   // template_slot, template_label,
                                            // pixels_upper, pixels_lower, pad
  input  wire [KIND_W-1:0]       s_tuser,   // kind
  // result stream
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // grade, matched_digit,
                                            // match_score, pad
  // config port
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [CFG_AW-1:0]       paddr,
  input  wire [CFG_DW-1:0]       pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int AW    = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
  localparam int CW    = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam int WORD_W = 1 + LABEL_W + GLYPH_PIXELS;
  localparam logic [AW-1:0] TOP_ADDR = AW'(TEMPLATES - 1);

  // Request fields
  logic [SLOT_W-1:0]       in_slot;
  logic [LABEL_W-1:0]      in_label;
  logic [GLYPH_PIXELS-1:0] in_pixels;
  logic                    s_accept;

  assign in_slot   = s_tdata[5:0];
  assign in_label  = s_tdata[9:6];
  assign in_pixels = s_tdata[75:10];   // lower rows above upper rows
  assign s_accept  = s_tvalid && s_tready;

  // Config registers
  logic [SCORE_W-1:0] min_set_pixels;
  logic [SCORE_W-1:0] learn_threshold;
  logic [SCORE_W-1:0] doubt_threshold;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_set_pixels  <= MIN_SET_RST;
      learn_threshold <= LEARN_RST;
      doubt_threshold <= DOUBT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MIN_SET: min_set_pixels  <= pwdata[SCORE_W-1:0];
        REG_LEARN:   learn_threshold <= pwdata[SCORE_W-1:0];
        REG_DOUBT:   doubt_threshold <= pwdata[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_SET: prdata = CFG_DW'(min_set_pixels);
      REG_LEARN:   prdata = CFG_DW'(learn_threshold);
      REG_DOUBT:   prdata = CFG_DW'(doubt_threshold);
      default:     prdata = '0;
    endcase
  end

  // Sequencer and datapath registers
  state_t                  state;
  logic [AW-1:0]           scan_addr;
  logic                    last_rd;
  logic [GLYPH_PIXELS-1:0] glyph;
  logic [SCORE_W-1:0]      best;
  logic [LABEL_W-1:0]      digit;
  logic                    found;
  logic                    blank;

  // Template memory: {valid, label, pixels}
  logic [WORD_W-1:0] mem [TEMPLATES];
  logic [WORD_W-1:0] rd_word;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [CW-1:0]     slot_ext;
  logic              load_we;

  assign slot_ext = CW'(in_slot);
  assign load_we  = s_accept && (s_tuser == KIND_LOAD) && (slot_ext < CW'(TEMPLATES));
  assign mem_we   = (state == ST_CLEAR) || load_we;
  assign mem_wa   = (state == ST_CLEAR) ? scan_addr : slot_ext[AW-1:0];
  assign mem_wd   = (state == ST_CLEAR) ? '0 : {1'b1, in_label, in_pixels};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_word <= mem[scan_addr];
  end

  // Shared popcount unit: lit count first, then agreement per slot
  logic                    rd_valid;
  logic [LABEL_W-1:0]      rd_label;
  logic [GLYPH_PIXELS-1:0] rd_pixels;
  logic [GLYPH_PIXELS-1:0] pop_in;
  logic [SCORE_W-1:0]      pop_cnt;

  assign rd_valid  = rd_word[WORD_W-1];
  assign rd_label  = rd_word[GLYPH_PIXELS +: LABEL_W];
  assign rd_pixels = rd_word[GLYPH_PIXELS-1:0];
  assign pop_in    = (state == ST_LIT) ? glyph : ~(glyph ^ rd_pixels);
  assign pop_cnt   = pop66(pop_in);

  // Grading of the final best score
  logic [GRADE_W-1:0] grade;

  always_comb begin
    if (blank) begin
      grade = GRADE_BLANK;
    end else if (!found) begin
      grade = GRADE_REJECTED;
    end else if (best >= FULL_SCORE) begin
      grade = GRADE_EXACT;
    end else if (best > learn_threshold) begin
      grade = GRADE_LEARNABLE;
    end else if (best > doubt_threshold) begin
      grade = GRADE_DOUBTFUL;
    end else begin
      grade = GRADE_REJECTED;
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_addr <= TOP_ADDR;
      last_rd   <= 1'b0;
      found     <= 1'b0;
      blank     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          scan_addr <= scan_addr - 1'b1;
          if (scan_addr == '0) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            case (s_tuser)
              KIND_CLASSIFY: begin
                glyph     <= in_pixels;
                best      <= '0;
                digit     <= '0;
                found     <= 1'b0;
                blank     <= 1'b0;
                scan_addr <= TOP_ADDR;
                state     <= ST_LIT;
              end
              KIND_CLEAR: begin
                scan_addr <= TOP_ADDR;
                state     <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_LIT: begin
          // top slot read is issued this cycle
          if (pop_cnt < min_set_pixels) begin
            blank <= 1'b1;
            state <= ST_FIN;
          end else begin
            last_rd   <= (scan_addr == '0);
            scan_addr <= scan_addr - 1'b1;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // first strict maximum from the top wins
          if (rd_valid && (!found || (pop_cnt > best))) begin
            found <= 1'b1;
            best  <= pop_cnt;
            digit <= rd_label;
          end
          if (last_rd) begin
            state <= ST_FIN;
          end else begin
            last_rd   <= (scan_addr == '0);
            scan_addr <= scan_addr - 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result valid: raised by the grade step, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= {2'b00, best, digit, grade};
    end
  end

endmodule
`default_nettype wire

### dv/tb_binary_glyph_template_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph template matcher testbench
// Streams load, classify and clear requests into the matcher and predicts
// every classify result from a shadow template table. Thresholds are changed
// between phases over the APB-style port, with the stream sides idling
// at random, then with a long result hold-off.
// ----------------------------------------------------------------------------
module tb_binary_glyph_template_matcher;
  import bgtm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0]        REG_NONE    = 2'd3;
  localparam int                CYCLE_LIMIT = 1000000;
  localparam int                SETTLE_CYC  = TEMPLATES_DEF + 16;
  localparam int                HOLD_CYC    = 600;
  localparam logic [GLYPH_PIXELS-1:0] ALL_LIT  = '1;
  localparam logic [GLYPH_PIXELS-1:0] SHAPE_A  = 66'h2_5A3C_9E17_0F6D_B481;

  typedef struct packed {
    logic [GRADE_W-1:0] grade;
    logic [LABEL_W-1:0] digit;
    logic [SCORE_W-1:0] score;
  } match_t;

  // Shadow template table, thresholds and queue of pending match results
  class glyph_scoreboard;
    logic [GLYPH_PIXELS-1:0] tpl_pix   [TEMPLATES_DEF];
    logic [LABEL_W-1:0]      tpl_digit [TEMPLATES_DEF];
    bit                      slot_live [TEMPLATES_DEF];
    logic [SCORE_W-1:0]      min_lit;
    logic [SCORE_W-1:0]      learn_lvl;
    logic [SCORE_W-1:0]      doubt_lvl;
    match_t                  match_q [$];
    int                      errors;

    function new();
      foreach (slot_live[s]) begin
        slot_live[s] = 1'b0;
        tpl_pix[s]   = '0;
        tpl_digit[s] = '0;
      end
      min_lit   = MIN_SET_RST;
      learn_lvl = LEARN_RST;
      doubt_lvl = DOUBT_RST;
      errors    = 0;
    endfunction

    static function int lit_count(logic [GLYPH_PIXELS-1:0] v);
      int n;
      n = 0;
      for (int i = 0; i < GLYPH_PIXELS; i++) n += int'(v[i]);
      return n;
    endfunction

    function void write_reg(logic [1:0] idx, logic [SCORE_W-1:0] v);
      case (idx)
        REG_MIN_SET: min_lit = v;
        REG_LEARN:   learn_lvl = v;
        REG_DOUBT:   doubt_lvl = v;
        default: ;
      endcase
    endfunction

    function logic [SCORE_W-1:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_MIN_SET: return min_lit;
        REG_LEARN:   return learn_lvl;
        default:     return doubt_lvl;
      endcase
    endfunction

    // Apply one accepted request; classify queues its predicted result
    function void note_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [LABEL_W-1:0] label,
                               logic [GLYPH_PIXELS-1:0] pix);
      match_t r;
      int     score;
      int     best;
      bit     found;
      case (kind)
        KIND_LOAD: begin
          tpl_pix[slot]   = pix;
          tpl_digit[slot] = label;
          slot_live[slot] = 1'b1;
        end
        KIND_CLEAR: begin
          foreach (slot_live[s]) slot_live[s] = 1'b0;
        end
        KIND_CLASSIFY: begin
          r = '{GRADE_BLANK, '0, '0};
          if (lit_count(pix) >= int'(min_lit)) begin
            found = 1'b0;
            best  = 0;
            // highest slot first, strict improvement only: top slot wins ties
            for (int s = TEMPLATES_DEF - 1; s >= 0; s--) begin
              if (slot_live[s]) begin
                score = GLYPH_PIXELS - lit_count(pix ^ tpl_pix[s]);
                if (!found || score > best) begin
                  found   = 1'b1;
                  best    = score;
                  r.digit = tpl_digit[s];
                end
              end
            end
            r.score = SCORE_W'(best);
            if (!found)                     r.grade = GRADE_REJECTED;
            else if (best >= GLYPH_PIXELS)  r.grade = GRADE_EXACT;
            else if (best > int'(learn_lvl)) r.grade = GRADE_LEARNABLE;
            else if (best > int'(doubt_lvl)) r.grade = GRADE_DOUBTFUL;
            else                            r.grade = GRADE_REJECTED;
          end
          match_q.insert(match_q.size(), r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      match_t e;
      logic [GRADE_W-1:0] got_grade;
      logic [LABEL_W-1:0] got_digit;
      logic [SCORE_W-1:0] got_score;
      got_grade = d[GRADE_W-1:0];
      got_digit = d[GRADE_W +: LABEL_W];
      got_score = d[GRADE_W+LABEL_W +: SCORE_W];
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got grade %0d digit %0d score %0d",
                 $time, got_grade, got_digit, got_score);
        errors++;
        return;
      end
      e = match_q.pop_front();
      if (got_grade !== e.grade) begin
        $display("%0t: grade mismatch: expected %0d, actual %0d", $time, e.grade, got_grade);
        errors++;
      end
      if (got_digit !== e.digit) begin
        $display("%0t: digit mismatch: expected %0d, actual %0d", $time, e.digit, got_digit);
        errors++;
      end
      if (got_score !== e.score) begin
        $display("%0t: score mismatch: expected %0d, actual %0d", $time, e.score, got_score);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // template_slot, template_label,
                                    // pixels_upper, pixels_lower, pad
  logic [KIND_W-1:0]     s_tuser;   // kind
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // grade, matched_digit, match_score, pad
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_AW-1:0]     paddr;
  logic [CFG_DW-1:0]     pwdata;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  glyph_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_ask;
  int hold_seen;
  int hold_left;
  int cycle_cnt;

  binary_glyph_template_matcher u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("binary_glyph_template_matcher test failed");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      hold_seen <= hold_ask;
      hold_left <= 0;
      m_tready  <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYC;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: results are checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[SLOT_W-1:0], s_tdata[SLOT_W +: LABEL_W],
                        s_tdata[SLOT_W+LABEL_W +: GLYPH_PIXELS]);
    end
  end

  function automatic logic [GLYPH_PIXELS-1:0] flip_bits(logic [GLYPH_PIXELS-1:0] v, int n);
    logic [GLYPH_PIXELS-1:0] done_m;
    int k;
    done_m = '0;
    while (n > 0) begin
      k = $urandom_range(0, GLYPH_PIXELS - 1);
      if (!done_m[k]) begin
        done_m[k] = 1'b1;
        v[k]      = ~v[k];
        n--;
      end
    end
    return v;
  endfunction

  function automatic logic [GLYPH_PIXELS-1:0] rand_pix();
    logic [95:0] w;
    w = {$urandom(), $urandom(), $urandom()};
    return w[GLYPH_PIXELS-1:0];
  endfunction

  // One request on the input stream, with random idle cycles before it
  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                          input logic [LABEL_W-1:0] label,
                          input logic [GLYPH_PIXELS-1:0] pix);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, pix, label, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val[SCORE_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [1:0] idx);
    logic [CFG_DW-1:0] want;
    want    = CFG_DW'(sb.reg_value(idx));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d readback mismatch: expected %0d, actual %0d",
               $time, idx, want, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int min_v, input int learn_v, input int doubt_v);
    cfg_write(REG_MIN_SET, {25'($urandom()), 7'(min_v)});
    cfg_write(REG_LEARN, CFG_DW'(learn_v));
    cfg_write(REG_DOUBT, CFG_DW'(doubt_v));
    cfg_read_check(REG_MIN_SET);
    cfg_read_check(REG_LEARN);
    cfg_read_check(REG_DOUBT);
  endtask

  // Drain all pending results, then cover a clear sweep still running
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    // the last request is noted by the monitor at this edge
    @(posedge clk);
    while (sb.match_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic run_directed();
    send_req(KIND_CLASSIFY, '0, '0, ALL_LIT);          // empty table
    send_req(KIND_CLASSIFY, '1, '1, '0);               // blank
    send_req(KIND_CLASSIFY, '0, '0, 66'h1FF);          // one short of the minimum
    send_req(KIND_CLASSIFY, '0, '0, 66'h3FF);          // exactly the minimum
    send_req(KIND_LOAD, 6'd63, 4'd0, ALL_LIT);
    send_req(KIND_CLASSIFY, '0, '0, ALL_LIT);          // perfect match
    send_req(KIND_LOAD, 6'd0, 4'd15, '0);
    send_req(KIND_LOAD, 6'd5, 4'd3, SHAPE_A);
    send_req(KIND_LOAD, 6'd40, 4'd7, SHAPE_A);
    send_req(KIND_CLASSIFY, '0, '0, SHAPE_A);          // tie, higher slot wins
    send_req(KIND_CLASSIFY, '0, '0, flip_bits(SHAPE_A, 5));
    send_req(KIND_CLASSIFY, '0, '0, flip_bits(SHAPE_A, 12));
    send_req(KIND_CLASSIFY, '0, '0, flip_bits(SHAPE_A, 20));
    send_req(KIND_UNUSED, '1, '1, ALL_LIT);            // ignored kind
    send_req(KIND_LOAD, 6'd40, 4'd9, ~SHAPE_A);        // overwrite
    send_req(KIND_CLASSIFY, '0, '0, SHAPE_A);
    send_req(KIND_CLEAR, '0, '0, '0);
    send_req(KIND_CLASSIFY, '0, '0, SHAPE_A);          // table cleared
    send_req(KIND_LOAD, 6'd0, 4'd12, '0);              // label above nine
    send_req(KIND_CLASSIFY, '0, '0, ALL_LIT);          // score of zero
    send_req(KIND_LOAD, 6'd33, 4'd10, ~SHAPE_A);
    send_req(KIND_CLASSIFY, '0, '0, ~SHAPE_A);
  endtask

  // Mostly classifies, often near stored templates, with noise; also loads and clears
  task automatic run_random(input int n_items);
    int                      live [$];
    int                      pick;
    logic [GLYPH_PIXELS-1:0] pix;
    for (int i = 0; i < n_items; i++) begin
      live.delete();
      for (int s = 0; s < TEMPLATES_DEF; s++) if (sb.slot_live[s]) live.insert(live.size(), s);
      pick = $urandom_range(0, 99);
      if (live.size() != 0 && $urandom_range(0, 1) == 0) begin
        pix = sb.tpl_pix[live[$urandom_range(0, live.size() - 1)]];
      end else begin
        pix = rand_pix();
      end
      if (pick < 3) begin
        send_req(KIND_CLEAR, SLOT_W'($urandom()), LABEL_W'($urandom()), rand_pix());
      end else if (pick < 6) begin
        send_req(KIND_UNUSED, SLOT_W'($urandom()), LABEL_W'($urandom()), rand_pix());
        i--;
      end else if (pick < 36) begin
        send_req(KIND_LOAD, SLOT_W'($urandom()), LABEL_W'($urandom()),
                 flip_bits(pix, $urandom_range(0, 6)));
      end else if (pick < 52) begin
        // lit count spread over the whole range, for the blank test
        send_req(KIND_CLASSIFY, SLOT_W'($urandom()), LABEL_W'($urandom()),
                 flip_bits('0, $urandom_range(0, GLYPH_PIXELS)));
      end else begin
        send_req(KIND_CLASSIFY, SLOT_W'($urandom()), LABEL_W'($urandom()),
                 flip_bits(pix, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24)));
      end
    end
  endtask

  initial begin
    sb          = new();
    tx_idle_pct = 33;
    rx_idle_pct <= 65;
    hold_ask    <= 0;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // let the post-reset clearing sweep finish
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cfg_read_check(REG_MIN_SET);
    cfg_read_check(REG_LEARN);
    cfg_read_check(REG_DOUBT);

    // Sender idles a third, receiver two thirds; reset thresholds
    run_directed();
    run_random(200);
    wait_idle();
    set_thresholds(0, 66, 66);
    run_random(250);
    wait_idle();

    // Roles swapped
    tx_idle_pct = 65;
    rx_idle_pct <= 33;
    set_thresholds(66, 0, 0);
    run_random(150);
    wait_idle();
    set_thresholds($urandom_range(0, 66), $urandom_range(0, 66), $urandom_range(0, 66));
    run_random(250);
    wait_idle();

    // No idling; long result hold-off so the block backs up; crossed thresholds
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    set_thresholds(5, 40, 60);
    hold_ask <= hold_ask + 1;
    run_random(300);
    wait_idle();
    cfg_write(REG_NONE, CFG_DW'($urandom()));  // no such register
    set_thresholds(10, 56, 50);
    run_random(300);
    wait_idle();

    if (sb.errors == 0) begin
      $display("binary_glyph_template_matcher test passed");
    end else begin
      $display("binary_glyph_template_matcher test failed");
    end
    $finish;
  end

endmodule
